@@ design/zcrs_pkg.sv @@
// zero-crossing relay sequencer: shared widths, phase codes and record types
// no dependencies; used by zcrs_step and zero_cross_relay_sequencer
package zcrs_pkg;

    localparam int RELAY_COUNT    = 4;
    localparam int SAMPLE_BITS    = 12;
    localparam int COUNTER_BITS   = 20;
    localparam int INDEX_BITS     = 2;
    localparam int ERR_BITS       = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_ON_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_OFF_TICKS = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_HIGH,
        PH_WAIT_LOW,
        PH_ON_THEN_OFF,
        PH_OFF_THEN_ON,
        PH_ON_LAST,
        PH_OFF_LAST
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]  high_threshold;
        logic [SAMPLE_BITS-1:0]  low_threshold;
        logic [COUNTER_BITS-1:0] timeout_ticks;
        logic [ERR_BITS-1:0]     error_limit;
        logic [COUNTER_BITS-1:0] delay_on_ticks;
        logic [COUNTER_BITS-1:0] delay_off_ticks;
    } cfg_t;

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
        logic [INDEX_BITS-1:0]  relay_index;
        logic                   turn_on;
    } item_t;

    typedef struct packed {
        phase_t                  phase;
        logic [COUNTER_BITS-1:0] cnt;
        logic [ERR_BITS-1:0]     err;
        logic                    fault;
        logic [RELAY_COUNT-1:0]  pend;
        logic [RELAY_COUNT-1:0]  tgt;
        logic [RELAY_COUNT-1:0]  relay;
        logic                    start;
    } state_t;

endpackage

@@ design/zcrs_step.sv @@
// zero-crossing relay sequencer: next-state logic for one transfer
// depends on zcrs_pkg
module zcrs_step
    import zcrs_pkg::*;
(
    input  state_t cur,
    input  cfg_t   cfg,
    input  item_t  item,
    output state_t nxt
);

    logic [COUNTER_BITS-1:0] diff;
    state_t                  work;

    function automatic state_t close_seq(state_t s);
        s.phase = PH_IDLE;
        s.start = (s.pend != '0);
        return s;
    endfunction

    function automatic state_t apply_ons(state_t s);
        logic [RELAY_COUNT-1:0] ons;
        ons     = s.pend & s.tgt;
        s.relay = s.relay | ons;
        s.pend  = s.pend & ~ons;
        return s;
    endfunction

    function automatic state_t apply_offs(state_t s);
        logic [RELAY_COUNT-1:0] offs;
        offs    = s.pend & ~s.tgt;
        s.relay = s.relay & ~offs;
        s.pend  = s.pend & ~offs;
        return s;
    endfunction

    function automatic state_t run_stage(state_t s, phase_t ph,
                                         logic [COUNTER_BITS-1:0] d,
                                         logic [COUNTER_BITS-1:0] dd);
        state_t r;
        r = s;
        if (d != '0)
        begin
            r.phase = ph;
            r.cnt   = d;
        end
        else
        begin
            unique case (ph)
                PH_ON_THEN_OFF:
                begin
                    r = apply_ons(r);
                    if (dd != '0)
                    begin
                        r.phase = PH_OFF_LAST;
                        r.cnt   = dd;
                    end
                    else
                    begin
                        r = close_seq(apply_offs(r));
                    end
                end
                PH_OFF_THEN_ON:
                begin
                    r = apply_offs(r);
                    if (dd != '0)
                    begin
                        r.phase = PH_ON_LAST;
                        r.cnt   = dd;
                    end
                    else
                    begin
                        r = close_seq(apply_ons(r));
                    end
                end
                PH_ON_LAST:
                begin
                    r = close_seq(apply_ons(r));
                end
                default:
                begin
                    r = close_seq(apply_offs(r));
                end
            endcase
        end
        return r;
    endfunction

    function automatic state_t crossing(state_t s, cfg_t c, logic [COUNTER_BITS-1:0] dd);
        logic [RELAY_COUNT-1:0] ons;
        logic [RELAY_COUNT-1:0] offs;
        state_t                 r;
        ons  = s.pend & s.tgt;
        offs = s.pend & ~s.tgt;
        if (ons != '0 && offs != '0)
        begin
            if (c.delay_off_ticks < c.delay_on_ticks)
                r = run_stage(s, PH_OFF_THEN_ON, c.delay_off_ticks, dd);
            else
                r = run_stage(s, PH_ON_THEN_OFF, c.delay_on_ticks, dd);
        end
        else if (ons != '0)
        begin
            r = run_stage(s, PH_ON_LAST, c.delay_on_ticks, dd);
        end
        else if (offs != '0)
        begin
            r = run_stage(s, PH_OFF_LAST, c.delay_off_ticks, dd);
        end
        else
        begin
            r = close_seq(s);
        end
        return r;
    endfunction

    function automatic state_t low_eval(state_t s, cfg_t c, logic [SAMPLE_BITS-1:0] smp,
                                        logic [COUNTER_BITS-1:0] dd);
        state_t r;
        if (smp <= c.low_threshold || s.cnt >= c.timeout_ticks)
        begin
            r = crossing(s, c, dd);
        end
        else
        begin
            r       = s;
            r.cnt   = s.cnt + COUNTER_BITS'(1);
            r.phase = PH_WAIT_LOW;
        end
        return r;
    endfunction

    function automatic state_t high_eval(state_t s, cfg_t c, logic [SAMPLE_BITS-1:0] smp,
                                         logic [COUNTER_BITS-1:0] dd);
        logic [ERR_BITS:0] inc;
        state_t            r;
        r   = s;
        inc = {1'b0, s.err} + (ERR_BITS+1)'(1);
        if (smp >= c.high_threshold)
        begin
            r.err   = '0;
            r.fault = 1'b0;
            r.cnt   = '0;
            r       = low_eval(r, c, smp, dd);
        end
        else if (s.cnt >= c.timeout_ticks)
        begin
            // saturating timeout count, fault once past the limit
            if (inc > {1'b0, c.error_limit})
            begin
                r.fault = 1'b1;
                if (c.error_limit == '1)
                    inc = {1'b0, c.error_limit};
                else
                    inc = {1'b0, c.error_limit} + (ERR_BITS+1)'(1);
            end
            r.err = inc[ERR_BITS-1:0];
            r.cnt = '0;
            r     = low_eval(r, c, smp, dd);
        end
        else
        begin
            r.cnt   = s.cnt + COUNTER_BITS'(1);
            r.phase = PH_WAIT_HIGH;
        end
        return r;
    endfunction

    always_comb
    begin
        if (cfg.delay_on_ticks > cfg.delay_off_ticks)
            diff = cfg.delay_on_ticks - cfg.delay_off_ticks;
        else
            diff = cfg.delay_off_ticks - cfg.delay_on_ticks;
    end

    always_comb
    begin
        nxt  = cur;
        work = cur;
        if (item.mode)
        begin
            if (int'(item.relay_index) < RELAY_COUNT)
            begin
                nxt.pend[item.relay_index] = 1'b1;
                nxt.tgt[item.relay_index]  = item.turn_on;
                nxt.start                  = 1'b1;
            end
        end
        else
        begin
            unique case (cur.phase)
                PH_IDLE:
                begin
                    if (cur.start)
                    begin
                        work.start = 1'b0;
                        work.cnt   = '0;
                        nxt        = high_eval(work, cfg, item.sample, diff);
                    end
                end
                PH_WAIT_HIGH:
                begin
                    nxt = high_eval(cur, cfg, item.sample, diff);
                end
                PH_WAIT_LOW:
                begin
                    nxt = low_eval(cur, cfg, item.sample, diff);
                end
                PH_ON_THEN_OFF, PH_OFF_THEN_ON, PH_ON_LAST, PH_OFF_LAST:
                begin
                    work.cnt = cur.cnt - COUNTER_BITS'(1);
                    if (work.cnt == '0)
                        nxt = run_stage(work, cur.phase, '0, diff);
                    else
                        nxt = work;
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/zero_cross_relay_sequencer.sv @@
// zero-crossing relay sequencer top level: input register, state and result registers
// depends on zcrs_pkg and zcrs_step
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_ready | mode, sample, relay_index, turn_on
//  result   | out_valid/out_ready | relay_outputs, pending_mask, busy_res, fault
//  config   | cfg_write           | cfg_index, cfg_data
//
// one transfer per cycle while the result is not stalled; a result passes the input register, then the state register
// the rate is set by the combinational next-state logic in zcrs_step
// reset clears the state and loads the default register values
// a stalled result holds the state; the input register still takes one more transfer
module zero_cross_relay_sequencer
    import zcrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic [INDEX_BITS-1:0]     relay_index,
    input  logic                      turn_on,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [RELAY_COUNT-1:0]    relay_outputs,
    output logic [RELAY_COUNT-1:0]    pending_mask,
    output logic                      busy_res,
    output logic                      fault,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [SAMPLE_BITS-1:0]  HIGH_THRESHOLD_RESET = 12'd3300;
    localparam logic [SAMPLE_BITS-1:0]  LOW_THRESHOLD_RESET  = 12'd700;
    localparam logic [COUNTER_BITS-1:0] TIMEOUT_RESET        = 20'd200000;
    localparam logic [ERR_BITS-1:0]     ERROR_LIMIT_RESET    = 2'd2;

    cfg_t   cfg_reg;
    item_t  item_reg;
    logic   item_valid_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    logic   advance;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold  <= HIGH_THRESHOLD_RESET;
            cfg_reg.low_threshold   <= LOW_THRESHOLD_RESET;
            cfg_reg.timeout_ticks   <= TIMEOUT_RESET;
            cfg_reg.error_limit     <= ERROR_LIMIT_RESET;
            cfg_reg.delay_on_ticks  <= '0;
            cfg_reg.delay_off_ticks <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HIGH_THRESHOLD:  cfg_reg.high_threshold  <= cfg_data[SAMPLE_BITS-1:0];
                REG_LOW_THRESHOLD:   cfg_reg.low_threshold   <= cfg_data[SAMPLE_BITS-1:0];
                REG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_data[COUNTER_BITS-1:0];
                REG_ERROR_LIMIT:     cfg_reg.error_limit     <= cfg_data[ERR_BITS-1:0];
                REG_DELAY_ON_TICKS:  cfg_reg.delay_on_ticks  <= cfg_data[COUNTER_BITS-1:0];
                REG_DELAY_OFF_TICKS: cfg_reg.delay_off_ticks <= cfg_data[COUNTER_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode        <= mode;
            item_reg.sample      <= sample;
            item_reg.relay_index <= relay_index;
            item_reg.turn_on     <= turn_on;
        end
    end

    zcrs_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (item_reg),
        .nxt  (state_next)
    );

    // state doubles as the result register: it only moves when the result slot frees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_outputs = state_reg.relay;
    assign pending_mask  = state_reg.pend;
    assign busy_res      = (state_reg.phase != PH_IDLE);
    assign fault         = state_reg.fault;

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state moved without a transfer");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(state_reg))
        else $error("result changed while stalled");

    a_countdown_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_ON_THEN_OFF || state_reg.phase == PH_OFF_THEN_ON ||
         state_reg.phase == PH_ON_LAST || state_reg.phase == PH_OFF_LAST)
        |-> state_reg.cnt != '0)
        else $error("switching delay counter at zero");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input blocked with empty result slot");

endmodule
